// ===== hw/rtl/spq_pkg.sv =====
// shared types and constants for the sorted priority queue
// no dependencies; imported by spq_cell and sorted_priority_queue_top
package spq_pkg;

  localparam int unsigned SpqDepth = 16;
  localparam int unsigned PayW     = 16;
  localparam int unsigned PriW     = 4;
  localparam int unsigned StatW    = 2;
  localparam int unsigned OccW     = 5;

  // request modes
  localparam logic MODE_ENQ = 1'b0;
  localparam logic MODE_DEQ = 1'b1;

  // result status codes
  localparam logic [StatW-1:0] ST_DONE  = 2'd0;
  localparam logic [StatW-1:0] ST_FULL  = 2'd1;
  localparam logic [StatW-1:0] ST_EMPTY = 2'd2;

  // control broadcast to every cell of the row
  typedef struct packed {
    logic            enq;
    logic            deq;
    logic [PayW-1:0] pay;
    logic [PriW-1:0] pri;
  } spq_ctrl_t;

endpackage

// ===== hw/rtl/spq_cell.sv =====
// one storage cell of the sorted row: holds one entry, compares and shifts
// depends on spq_pkg
module spq_cell (
  input  logic                    clk_i,
  input  spq_pkg::spq_ctrl_t      ctrl_i,
  input  logic                    occupied_i,
  input  logic                    left_ge_i,
  input  logic [spq_pkg::PayW-1:0] left_pay_i,
  input  logic [spq_pkg::PriW-1:0] left_pri_i,
  input  logic [spq_pkg::PayW-1:0] right_pay_i,
  input  logic [spq_pkg::PriW-1:0] right_pri_i,
  output logic                    ge_o,
  output logic [spq_pkg::PayW-1:0] pay_o,
  output logic [spq_pkg::PriW-1:0] pri_o
);
  import spq_pkg::*;

  logic [PayW-1:0] pay_q, pay_d;
  logic [PriW-1:0] pri_q, pri_d;

  // entry stays ahead of the new one when its priority is equal or higher
  assign ge_o = occupied_i && (pri_q >= ctrl_i.pri);

  // keep, take the new entry, take the left entry, or take the right entry
  always_comb begin
    pay_d = pay_q;
    pri_d = pri_q;
    if (ctrl_i.enq && !ge_o) begin
      if (left_ge_i) begin
        pay_d = ctrl_i.pay;
        pri_d = ctrl_i.pri;
      end else begin
        pay_d = left_pay_i;
        pri_d = left_pri_i;
      end
    end else if (ctrl_i.deq) begin
      pay_d = right_pay_i;
      pri_d = right_pri_i;
    end
  end

  // entry storage, no reset
  always_ff @(posedge clk_i) begin
    pay_q <= pay_d;
    pri_q <= pri_d;
  end

  assign pay_o = pay_q;
  assign pri_o = pri_q;

endmodule

// ===== hw/rtl/sorted_priority_queue_top.sv =====
// sorted priority queue: row of compare-and-shift cells, fill counter, result register
// depends on spq_pkg and spq_cell
//
// usage
//   input channel: in_valid_i / in_stall_o with mode_i, payload_i, priority_req_i.
//   mode enqueue inserts the entry behind all entries of equal or higher
//   priority; mode dequeue removes the head entry.
//   output channel: out_valid_o / out_stall_i with status_o, out_payload_o,
//   out_priority_o and occupancy_o; every request gives exactly one result.
//   result: registered, valid in the cycle after the request is taken.
//   throughput: one request per cycle while in_stall_o is low; all cells compare
//   against the new priority and shift in the same cycle, so the row itself never waits.
//   stall: while a result waits under out_stall_i the block holds in_stall_o
//   high; once it is taken a new request is accepted in that same cycle.
//   reset: rst_ni (async, active low) empties the queue and drops out_valid_o;
//   the entry storage is not cleared, slots past the fill count are never read.
//   occupancy_o carries the low five bits of the fill count.
module sorted_priority_queue_top #(
  parameter int unsigned DEPTH = spq_pkg::SpqDepth
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic                      mode_i,
  input  logic [spq_pkg::PayW-1:0]  payload_i,
  input  logic [spq_pkg::PriW-1:0]  priority_req_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic [spq_pkg::StatW-1:0] status_o,
  output logic [spq_pkg::PayW-1:0]  out_payload_o,
  output logic [spq_pkg::PriW-1:0]  out_priority_o,
  output logic [spq_pkg::OccW-1:0]  occupancy_o
);
  import spq_pkg::*;

  localparam int unsigned CntW = $clog2(DEPTH + 1);

  logic [CntW-1:0]  count_q, count_d;
  logic             out_valid_q;
  logic [StatW-1:0] status_q, status_d;
  logic [PayW-1:0]  opay_q, opay_d;
  logic [PriW-1:0]  opri_q, opri_d;
  logic [OccW-1:0]  occ_q, occ_d;
  logic [31:0]      count_ext;

  logic             take;
  logic             full;
  logic             empty;
  spq_ctrl_t        ctrl;

  logic [PayW-1:0]  cell_pay [DEPTH];
  logic [PriW-1:0]  cell_pri [DEPTH];
  logic             cell_ge  [DEPTH];

  // handshake
  assign in_stall_o = out_valid_q && out_stall_i;
  assign take       = in_valid_i && !in_stall_o;
  assign full       = (count_q == CntW'(DEPTH));
  assign empty      = (count_q == '0);

  // control for the cell row
  always_comb begin
    ctrl.enq = take && (mode_i == MODE_ENQ) && !full;
    ctrl.deq = take && (mode_i == MODE_DEQ) && !empty;
    ctrl.pay = payload_i;
    ctrl.pri = priority_req_i;
  end

  // row of cells
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic            left_ge;
    logic [PayW-1:0] left_pay, right_pay;
    logic [PriW-1:0] left_pri, right_pri;

    if (i == 0) begin : g_first
      assign left_ge  = 1'b1;
      assign left_pay = payload_i;
      assign left_pri = priority_req_i;
    end else begin : g_mid
      assign left_ge  = cell_ge[i-1];
      assign left_pay = cell_pay[i-1];
      assign left_pri = cell_pri[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign right_pay = cell_pay[i];
      assign right_pri = cell_pri[i];
    end else begin : g_inner
      assign right_pay = cell_pay[i+1];
      assign right_pri = cell_pri[i+1];
    end

    spq_cell u_cell (
      .clk_i      (clk_i),
      .ctrl_i     (ctrl),
      .occupied_i (CntW'(i) < count_q),
      .left_ge_i  (left_ge),
      .left_pay_i (left_pay),
      .left_pri_i (left_pri),
      .right_pay_i(right_pay),
      .right_pri_i(right_pri),
      .ge_o       (cell_ge[i]),
      .pay_o      (cell_pay[i]),
      .pri_o      (cell_pri[i])
    );
  end

  // fill count and result fields
  always_comb begin
    count_d  = count_q;
    status_d = ST_DONE;
    opay_d   = '0;
    opri_d   = '0;
    if (mode_i == MODE_ENQ) begin
      if (full) begin
        status_d = ST_FULL;
      end else begin
        count_d = count_q + CntW'(1);
      end
    end else begin
      if (empty) begin
        status_d = ST_EMPTY;
      end else begin
        opay_d  = cell_pay[0];
        opri_d  = cell_pri[0];
        count_d = count_q - CntW'(1);
      end
    end
    count_ext = 32'(count_d);
    occ_d     = count_ext[OccW-1:0];
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (take) begin
        count_q <= count_d;
      end
      if (take) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (take) begin
      status_q <= status_d;
      opay_q   <= opay_d;
      opri_q   <= opri_d;
      occ_q    <= occ_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = status_q;
  assign out_payload_o  = opay_q;
  assign out_priority_o = opri_q;
  assign occupancy_o    = occ_q;

  // fill count stays within the row
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(DEPTH))
    else $error("fill count exceeds depth");

  // a taken enqueue on a non-full queue grows the count by one
  a_enq_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.enq |=> count_q == $past(count_q) + CntW'(1))
    else $error("enqueue did not grow the fill count");

  // a refused dequeue reports an empty queue with zero occupancy and payload
  a_empty_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && status_q == ST_EMPTY) |-> (occ_q == '0 && opay_q == '0))
    else $error("empty result with nonzero fields");

endmodule

// ===== tb/sv/testbench.sv =====
// self-checking testbench for sorted_priority_queue_top: directed table, then random bursts
// depends on spq_pkg and the queue rtl; a local sorted-list model predicts each result a directed row does not give
`timescale 1ns / 1ps

module testbench;
  import spq_pkg::*;

  localparam int unsigned QueueDepth     = SpqDepth;
  localparam int          RandomPerPhase = 410;
  localparam int          HoldOffCycles  = 60;
  localparam int          DrainCycles    = 5;
  localparam int          IdleLimit      = 2000;

  typedef struct packed {
    logic [StatW-1:0] status;
    logic [PayW-1:0]  pay;
    logic [PriW-1:0]  pri;
    logic [OccW-1:0]  occ;
  } queue_result_t;

  typedef struct packed {
    logic            mode;
    logic [PayW-1:0] pay;
    logic [PriW-1:0] pri;
    logic            typed;
    queue_result_t   exp;
  } queue_request_t;

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_stall_o;
  logic               mode_i;
  logic [PayW-1:0]    payload_i;
  logic [PriW-1:0]    priority_req_i;
  logic               out_valid_o;
  logic               out_stall_i;
  logic [StatW-1:0]   status_o;
  logic [PayW-1:0]    out_payload_o;
  logic [PriW-1:0]    out_priority_o;
  logic [OccW-1:0]    occupancy_o;

  // typed expectation travels with the request it belongs to
  logic               req_typed;
  queue_result_t      req_exp;

  // model of the sorted store
  logic [PayW-1:0]    sorted_pay [QueueDepth];
  logic [PriW-1:0]    sorted_pri [QueueDepth];
  int                 stored_count = 0;

  queue_result_t      pending_results [$];
  int                 errors = 0;
  int                 idle_pct = 20;
  int                 stall_pct = 70;
  bit                 hold_off_req = 1'b0;
  int                 idle_cycles = 0;
  queue_result_t      got_result;
  queue_result_t      want_result;

  // directed requests: empty, extremes, ties, full
  queue_request_t directed_rows [25] = '{
    '{MODE_DEQ, 16'h1234, 4'h9, 1'b1, '{ST_EMPTY, 16'h0000, 4'h0, 5'd0}},
    '{MODE_ENQ, 16'hFFFF, 4'hF, 1'b1, '{ST_DONE,  16'h0000, 4'h0, 5'd1}},
    '{MODE_DEQ, 16'h0000, 4'h0, 1'b1, '{ST_DONE,  16'hFFFF, 4'hF, 5'd0}},
    '{MODE_ENQ, 16'h0000, 4'h0, 1'b1, '{ST_DONE,  16'h0000, 4'h0, 5'd1}},
    '{MODE_ENQ, 16'hA001, 4'h5, 1'b0, '0},
    '{MODE_ENQ, 16'hA002, 4'h5, 1'b0, '0},
    '{MODE_ENQ, 16'hA003, 4'hF, 1'b0, '0},
    '{MODE_ENQ, 16'hA004, 4'h0, 1'b0, '0},
    '{MODE_ENQ, 16'hA005, 4'h8, 1'b0, '0},
    '{MODE_ENQ, 16'hA006, 4'h5, 1'b0, '0},
    '{MODE_ENQ, 16'h5555, 4'h3, 1'b0, '0},
    '{MODE_ENQ, 16'hAAAA, 4'hC, 1'b0, '0},
    '{MODE_ENQ, 16'hA009, 4'hF, 1'b0, '0},
    '{MODE_ENQ, 16'hA00A, 4'h1, 1'b0, '0},
    '{MODE_ENQ, 16'hA00B, 4'hA, 1'b0, '0},
    '{MODE_ENQ, 16'hA00C, 4'h6, 1'b0, '0},
    '{MODE_ENQ, 16'hA00D, 4'h4, 1'b0, '0},
    '{MODE_ENQ, 16'hA00E, 4'h9, 1'b0, '0},
    '{MODE_ENQ, 16'hA00F, 4'h2, 1'b0, '0},
    '{MODE_ENQ, 16'h7777, 4'hF, 1'b1, '{ST_FULL,  16'h0000, 4'h0, 5'd16}},
    '{MODE_DEQ, 16'hFFFF, 4'hF, 1'b0, '0},
    '{MODE_DEQ, 16'h0000, 4'h0, 1'b0, '0},
    '{MODE_ENQ, 16'h8000, 4'h7, 1'b0, '0},
    '{MODE_DEQ, 16'h0F0F, 4'h3, 1'b0, '0},
    '{MODE_DEQ, 16'hF0F0, 4'hC, 1'b0, '0}
  };

  sorted_priority_queue_top #(
    .DEPTH(QueueDepth)
  ) DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .mode_i         (mode_i),
    .payload_i      (payload_i),
    .priority_req_i (priority_req_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .status_o       (status_o),
    .out_payload_o  (out_payload_o),
    .out_priority_o (out_priority_o),
    .occupancy_o    (occupancy_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // insert or pop on the model store, return the result the block should give
  function automatic queue_result_t predict_queue_op(input logic mode,
                                                     input logic [PayW-1:0] pay,
                                                     input logic [PriW-1:0] pri);
    queue_result_t res;
    int            slot;
    int            i;
    res = '0;
    res.status = ST_DONE;
    if (mode == MODE_ENQ) begin
      if (stored_count >= QueueDepth) begin
        res.status = ST_FULL;
      end else begin
        // new entry lands behind every entry of equal or higher priority
        slot = 0;
        while (slot < stored_count && sorted_pri[slot] >= pri) slot++;
        for (i = stored_count; i > slot; i--) begin
          sorted_pay[i] = sorted_pay[i-1];
          sorted_pri[i] = sorted_pri[i-1];
        end
        sorted_pay[slot] = pay;
        sorted_pri[slot] = pri;
        stored_count++;
      end
    end else if (stored_count == 0) begin
      res.status = ST_EMPTY;
    end else begin
      res.pay = sorted_pay[0];
      res.pri = sorted_pri[0];
      for (i = 1; i < stored_count; i++) begin
        sorted_pay[i-1] = sorted_pay[i];
        sorted_pri[i-1] = sorted_pri[i];
      end
      stored_count--;
    end
    res.occ = OccW'(stored_count);
    return res;
  endfunction

  task automatic check_field(input string name, input logic [15:0] want, input logic [15:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
      errors++;
    end
  endtask

  // offer one request, optionally after an idle gap, and wait until it is taken
  task automatic send_request(input queue_request_t req);
    if ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    mode_i         <= req.mode;
    payload_i      <= req.pay;
    priority_req_i <= req.pri;
    req_typed      <= req.typed;
    req_exp        <= req.exp;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  // result side: random stall, plus a long hold-off on request
  initial begin
    out_stall_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_stall_i <= 1'b1;
        repeat (HoldOffCycles) @(posedge clk_i);
      end
      out_stall_i <= ($urandom_range(99) < stall_pct);
    end
  end

  // check taken results first, then record the prediction for a taken request
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        got_result = {status_o, out_payload_o, out_priority_o, occupancy_o};
        if (pending_results.size() == 0) begin
          $display("%0t: unexpected result, expected none actual %0h", $time, got_result);
          errors++;
        end else begin
          want_result = pending_results.pop_front();
          check_field("status", 16'(want_result.status), 16'(got_result.status));
          check_field("out_payload", want_result.pay, got_result.pay);
          check_field("out_priority", 16'(want_result.pri), 16'(got_result.pri));
          check_field("occupancy", 16'(want_result.occ), 16'(got_result.occ));
        end
      end
      if (in_valid_i && !in_stall_o) begin
        want_result = predict_queue_op(mode_i, payload_i, priority_req_i);
        if (req_typed) want_result = req_exp;
        pending_results.push_back(want_result);
      end
    end
  end

  // watchdog on cycles with no handshake on either side
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= IdleLimit) begin
          $display("FAIL sorted_priority_queue_top");
          $finish;
        end
      end
    end
  end

  // stimulus
  initial begin
    queue_request_t req;
    int             phase;
    int             sent;
    int             burst_len;
    int             enq_pct;
    int             pri_base;
    bit             narrow;
    int             k;

    in_valid_i     <= 1'b0;
    mode_i         <= MODE_ENQ;
    payload_i      <= '0;
    priority_req_i <= '0;
    req_typed      <= 1'b0;
    req_exp        <= '0;
    rst_ni         <= 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (directed_rows[i]) send_request(directed_rows[i]);

    for (phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          idle_pct  = 20;
          stall_pct = 70;
        end
        1: begin
          idle_pct  = 70;
          stall_pct = 20;
        end
        default: begin
          idle_pct     = 0;
          stall_pct    = 0;
          hold_off_req = 1'b1;
        end
      endcase
      sent = 0;
      while (sent < RandomPerPhase) begin
        // bursts that mostly fill, mostly drain or mix
        burst_len = $urandom_range(8, 40);
        case ($urandom_range(0, 9))
          0, 1, 2, 3: enq_pct = 85;
          4, 5, 6, 7: enq_pct = 15;
          default:    enq_pct = 50;
        endcase
        // narrow priority window to get many ties
        narrow   = ($urandom_range(0, 2) == 0);
        pri_base = $urandom_range(0, 13);
        for (k = 0; k < burst_len && sent < RandomPerPhase; k++) begin
          req       = '0;
          req.mode  = ($urandom_range(99) < enq_pct) ? MODE_ENQ : MODE_DEQ;
          req.pay   = PayW'($urandom);
          req.pri   = narrow ? PriW'(pri_base + $urandom_range(0, 2)) : PriW'($urandom);
          send_request(req);
          sent++;
        end
      end
    end
    in_valid_i <= 1'b0;

    // let outstanding results drain
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (errors == 0) begin
      $display("PASS sorted_priority_queue_top");
    end else begin
      $display("FAIL sorted_priority_queue_top");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/spq_pkg.sv
hw/rtl/spq_cell.sv
hw/rtl/sorted_priority_queue_top.sv
tb/sv/testbench.sv
